/* rtl/bs64_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs64_pkg
// Shared types, character constants and alphabet mapping for the base64 codec.
// ----------------------------------------------------------------------------
package bs64_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_PAD     = 8'h3d;

    localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
    localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
    localparam logic [5:0] VAL_PLUS       = 6'd62;
    localparam logic [5:0] VAL_SLASH      = 6'd63;

    localparam int GROUP_W = 2;
    localparam int HELD_W  = 18;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
    } t_out_item;

    // results caused by one input word, first result in bytes[0]
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            msg_last;
    } t_job;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < VAL_LOWER_BASE) begin
            r = CH_UPPER_A + {2'b00, v};
        end else if (v < VAL_DIGIT_BASE) begin
            r = CH_LOWER_A + {2'b00, v - VAL_LOWER_BASE};
        end else if (v < VAL_PLUS) begin
            r = CH_DIGIT_0 + {2'b00, v - VAL_DIGIT_BASE};
        end else if (v == VAL_PLUS) begin
            r = CH_PLUS;
        end else begin
            r = CH_SLASH;
        end
        return r;
    endfunction

    // anything outside the alphabet, pad included, maps to zero
    function automatic logic [5:0] char_value(input logic [7:0] c);
        logic [5:0] r;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = 6'(c - CH_UPPER_A);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            r = 6'(c - CH_LOWER_A) + VAL_LOWER_BASE;
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            r = 6'(c - CH_DIGIT_0) + VAL_DIGIT_BASE;
        end else if (c == CH_PLUS) begin
            r = VAL_PLUS;
        end else if (c == CH_SLASH) begin
            r = VAL_SLASH;
        end else begin
            r = 6'd0;
        end
        return r;
    endfunction

endpackage

/* rtl/bs64_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs64_front
// Accepts input words, tracks group state and builds the result job per word.
// ----------------------------------------------------------------------------
module bs64_front
    import bs64_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    input  logic     i_cfg_we,
    input  logic     i_cfg_mode,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    logic              r_mode;
    logic [GROUP_W-1:0] r_pos;
    logic [HELD_W-1:0]  r_held;
    logic              r_third_pad;
    logic [GROUP_W-1:0] n_pos;
    logic [HELD_W-1:0]  n_held;
    logic              n_third_pad;
    logic              accept;
    t_job              job;
    logic [7:0]        b;
    logic              last;
    logic [5:0]        d;
    logic [5:0]        va;
    logic [5:0]        vb;
    logic [5:0]        vc;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign b          = i_in_data.in_byte;
    assign last       = i_in_data.in_last;
    assign d          = char_value(b);
    assign va         = r_held[17:12];
    assign vb         = r_held[11:6];
    assign vc         = r_held[5:0];

    always_comb begin
        job          = '0;
        job.msg_last = last;
        n_pos        = r_pos;
        n_held       = r_held;
        n_third_pad  = r_third_pad;
        if (r_mode == MODE_ENCODE) begin
            case (r_pos)
                2'd0: begin
                    job.bytes[0] = enc_char(b[7:2]);
                    job.count    = 3'd1;
                    n_held       = {16'd0, b[1:0]};
                    n_pos        = 2'd1;
                    if (last) begin
                        job.bytes[1] = enc_char({b[1:0], 4'b0000});
                        job.bytes[2] = CH_PAD;
                        job.bytes[3] = CH_PAD;
                        job.count    = 3'd4;
                    end
                end
                2'd1: begin
                    job.bytes[0] = enc_char({r_held[1:0], b[7:4]});
                    job.count    = 3'd1;
                    n_held       = {14'd0, b[3:0]};
                    n_pos        = 2'd2;
                    if (last) begin
                        job.bytes[1] = enc_char({b[3:0], 2'b00});
                        job.bytes[2] = CH_PAD;
                        job.count    = 3'd3;
                    end
                end
                default: begin
                    job.bytes[0] = enc_char({r_held[3:0], b[7:6]});
                    job.bytes[1] = enc_char(b[5:0]);
                    job.count    = 3'd2;
                    n_held       = '0;
                    n_pos        = 2'd0;
                end
            endcase
            if (last) begin
                n_pos       = '0;
                n_held      = '0;
                n_third_pad = 1'b0;
            end
        end else begin
            if (r_pos != 2'd3) begin
                if (r_pos == 2'd2) begin
                    n_third_pad = (b == CH_PAD);
                end
                n_held = {r_held[11:0], d};
                n_pos  = r_pos + 2'd1;
                if (last) begin
                    n_pos       = '0;
                    n_held      = '0;
                    n_third_pad = 1'b0;
                end
            end else begin
                job.bytes[0] = {va, vb[5:4]};
                job.bytes[1] = {vb[3:0], vc[5:2]};
                job.bytes[2] = {vc[1:0], d};
                job.count    = 3'd3 - {2'b00, last && (b == CH_PAD)}
                                    - {2'b00, last && r_third_pad};
                n_pos        = '0;
                n_held       = '0;
                n_third_pad  = 1'b0;
            end
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.count != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ENCODE;
            r_pos       <= '0;
            r_held      <= '0;
            r_third_pad <= 1'b0;
        end else if (i_cfg_we) begin
            // a mode write abandons any group in progress
            r_mode      <= i_cfg_mode;
            r_pos       <= '0;
            r_held      <= '0;
            r_third_pad <= 1'b0;
        end else if (accept) begin
            r_pos       <= n_pos;
            r_held      <= n_held;
            r_third_pad <= n_third_pad;
        end
    end

endmodule

/* rtl/bs64_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs64_queue
// Short first-in first-out queue of result jobs between front and back.
// ----------------------------------------------------------------------------
module bs64_queue
    import bs64_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int AW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/bs64_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs64_back
// Sends queued job results one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module bs64_back
    import bs64_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_q_empty,
    output logic      o_pop,
    output logic      o_idle,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_job       r_job;
    t_job       n_job;
    logic       r_busy;
    logic       n_busy;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       adv;
    logic       fin;

    // output register moves when empty or when its word is taken
    assign adv = !r_out_valid || !i_out_stall;
    assign fin = ({1'b0, r_idx} + 3'd1) == r_job.count;

    always_comb begin
        n_job       = r_job;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (adv && r_busy) begin
            n_out_valid       = 1'b1;
            n_out.out_byte    = r_job.bytes[r_idx];
            n_out.run_last    = fin;
            n_out.message_end = fin && r_job.msg_last;
            if (fin) begin
                n_busy = 1'b0;
                n_idx  = '0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end else if (adv) begin
            n_out_valid = 1'b0;
        end
        // refill the job register without a bubble between jobs
        if (!n_busy && !i_q_empty) begin
            o_pop  = 1'b1;
            n_job  = i_job;
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_idle      = !r_busy && !r_out_valid;

endmodule

/* rtl/base64_stream_codec_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_core
// Streaming base64 encoder / decoder with a mode register.
// ----------------------------------------------------------------------------
// One input word is taken per cycle while the job queue has room; the front
// stage turns it into up to four result words in that same cycle. Results
// leave through a registered output at one word per cycle while the output
// is not stalled, so in encoding the output port sets the sustained rate:
// two characters for the third byte of each triple, up to four for a final
// byte. When the block is empty the first result passes through the job
// queue, the job register of the back stage and the output register. Mode
// writes are taken only when the queue and the output are empty and no input
// word is offered; a write clears any group in progress.
module base64_stream_codec_core
    import bs64_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_data,
    output logic      o_cfg_ready
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    logic back_idle;
    logic cfg_we;
    t_job push_job;
    t_job head_job;

    // no input word may land on the same edge as a mode write
    assign o_cfg_ready = q_empty && back_idle && !i_in_valid;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    bs64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_mode (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    bs64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bs64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_idle      (back_idle),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

/* rtl/bs64_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs64_checker
// Port-level checks on the codec core, attached by bind.
// ----------------------------------------------------------------------------
module bs64_checker
    import bs64_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall,
    input logic      i_cfg_valid,
    input logic      o_cfg_ready
);

    // message end only ever closes a run
    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.message_end || o_out_data.run_last))
        else $error("message_end without run_last");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

    // mode port is open only while nothing is in flight
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_out_valid)
        else $error("cfg ready with output pending");

    // a mode write never conjures a result
    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && !i_in_valid) |=> !o_out_valid)
        else $error("output word after mode write");

endmodule

bind base64_stream_codec_core bs64_checker u_bs64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
